/* sv/ncfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncfs_pkg
// Shared types, register indexes and the quarter-wave sine generator for the
// NCO frequency shifter.
// ----------------------------------------------------------------------------
package ncfs_pkg;

  localparam int TRIG_BITS      = 17;
  localparam int MAG_BITS       = 15;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 32;
  localparam int FRAC_BITS      = 15;

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic [MAG_BITS-1:0]         mag_t;
  typedef logic [CFG_INDEX_BITS-1:0]   cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]    cfg_data_t;

  localparam cfg_index_t CFG_PHASE_STEP = cfg_index_t'(0);
  localparam cfg_index_t CFG_BYPASS     = cfg_index_t'(1);

  localparam logic [63:0] Q15_MAX     = 64'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // round(32767 * sin(pi/2 * k / 2^addr_bits)), Q2.30 taylor series to x^13
  function automatic mag_t quarter_sine(input logic [63:0] k, input int addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (k * HALF_PI_Q30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 6;
    sum  = x - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    r    = (sum * Q15_MAX + (64'd1 << 29)) >> 30;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end
    return r[MAG_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/ncfs_sincos.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncfs_sincos
// Quarter-wave sine table with two registered read ports. Folds the quadrant
// into a table index and a sign for both sine and cosine.
// ----------------------------------------------------------------------------
module ncfs_sincos #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [TABLE_ADDR_BITS+1:0] phase_idx,
  output ncfs_pkg::trig_t                 sin_val,
  output ncfs_pkg::trig_t                 cos_val
);
  import ncfs_pkg::*;

  localparam int ENTRIES = (1 << TABLE_ADDR_BITS) + 1;
  localparam int IDX_W   = TABLE_ADDR_BITS + 1;
  localparam logic [IDX_W-1:0] FULL = IDX_W'(1 << TABLE_ADDR_BITS);

  mag_t rom [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    assign rom[g] = quarter_sine(64'(g), TABLE_ADDR_BITS);
  end

  logic [1:0]       quad;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] sin_addr;
  logic [IDX_W-1:0] cos_addr;
  mag_t             sin_mag_r;
  mag_t             cos_mag_r;
  logic             sin_neg_r;
  logic             cos_neg_r;

  assign quad     = phase_idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  assign k        = {1'b0, phase_idx[TABLE_ADDR_BITS-1:0]};
  // cosine sits one quadrant ahead
  assign sin_addr = quad[0] ? FULL - k : k;
  assign cos_addr = quad[0] ? k : FULL - k;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag_r <= rom[sin_addr];
      cos_mag_r <= rom[cos_addr];
      sin_neg_r <= quad[1];
      cos_neg_r <= quad[1] ^ quad[0];
    end
  end

  assign sin_val = sin_neg_r ? -trig_t'({2'b00, sin_mag_r}) : trig_t'({2'b00, sin_mag_r});
  assign cos_val = cos_neg_r ? -trig_t'({2'b00, cos_mag_r}) : trig_t'({2'b00, cos_mag_r});

endmodule
`default_nettype wire

/* sv/nco_complex_frequency_shifter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes one complex sample per clock and delivers one rotated sample per
// clock unless the output stalls. The phase accumulator is updated in
// the acceptance cycle, the sine and cosine come from one table read on two
// registered ports, then one stage of four multipliers and one stage of add,
// truncation toward zero and saturation. Each pipeline stage moves on as soon
// as the stage after it is free, so input is taken while a result waits.
// ----------------------------------------------------------------------------
// nco_complex_frequency_shifter
// NCO complex mixer: rotates each I/Q sample by a running phase to apply a
// constant frequency shift, with burst restart, bypass and clip flag.
// ----------------------------------------------------------------------------
module nco_complex_frequency_shifter #(
  parameter  int PHASE_BITS      = 32,
  parameter  int TABLE_ADDR_BITS = 10,
  parameter  int SAMPLE_BITS     = 16,
  localparam int DATA_W          = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [DATA_W-1:0]          in_tdata,   // sample_re, sample_im
  input  wire logic                       in_tuser,   // burst_start
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [DATA_W-1:0]               out_tdata,  // rotated_re, rotated_im
  output logic                            out_tuser,  // clipped
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire ncfs_pkg::cfg_index_t       cfg_index,
  input  wire ncfs_pkg::cfg_data_t        cfg_data
);
  import ncfs_pkg::*;

  localparam int PW = SAMPLE_BITS + TRIG_BITS;
  localparam int QW = PW + 1 - FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [PW:0]            sum_t;
  typedef logic signed [QW-1:0]          quo_t;

  // configuration
  logic [STEP_BITS-1:0]  step_r;
  logic                  bypass_r;
  logic [PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS+STEP_BITS-1:0] step_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      bypass_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: step_r   <= cfg_data[STEP_BITS-1:0];
        CFG_BYPASS:     bypass_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step_wide = {{PHASE_BITS{step_r[STEP_BITS-1]}}, step_r};
  assign step_ext  = step_wide[PHASE_BITS-1:0];

  // pipeline flow
  logic v1_r, v2_r, out_valid_r;
  logic free1, free2, free3;
  logic load1, load2, load3;

  assign free3     = !out_valid_r || out_tready;
  assign free2     = !v2_r || free3;
  assign free1     = !v1_r || free2;
  assign load3     = v2_r && free3;
  assign load2     = v1_r && free2;
  assign load1     = in_tvalid && free1;
  assign in_tready = free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) v1_r        <= in_tvalid;
      if (free2) v2_r        <= v1_r;
      if (free3) out_valid_r <= v2_r;
    end
  end

  // phase accumulator
  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] phase_used;
  logic [PHASE_BITS-1:0] acc_nxt;

  assign phase_used = in_tuser ? '0 : acc_r;
  assign acc_nxt    = phase_used + step_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load1) begin
      acc_r <= acc_nxt;
    end
  end

  // stage 1: sample capture and table read
  smp_t  re1_r, im1_r;
  logic  byp1_r;
  trig_t sin_v, cos_v;

  ncfs_sincos #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_sincos (
    .clk      (clk),
    .en       (load1),
    .phase_idx(phase_used[PHASE_BITS-1 -: TABLE_ADDR_BITS+2]),
    .sin_val  (sin_v),
    .cos_val  (cos_v)
  );

  always_ff @(posedge clk) begin
    if (load1) begin
      re1_r  <= in_tdata[SAMPLE_BITS-1:0];
      im1_r  <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      byp1_r <= bypass_r;
    end
  end

  // stage 2: products
  prod_t p_rc_r, p_is_r, p_rs_r, p_ic_r;
  prod_t p_rc_nxt, p_is_nxt, p_rs_nxt, p_ic_nxt;
  smp_t  re2_r, im2_r;
  logic  byp2_r;

  assign p_rc_nxt = prod_t'(re1_r) * prod_t'(cos_v);
  assign p_is_nxt = prod_t'(im1_r) * prod_t'(sin_v);
  assign p_rs_nxt = prod_t'(re1_r) * prod_t'(sin_v);
  assign p_ic_nxt = prod_t'(im1_r) * prod_t'(cos_v);

  always_ff @(posedge clk) begin
    if (load2) begin
      p_rc_r <= p_rc_nxt;
      p_is_r <= p_is_nxt;
      p_rs_r <= p_rs_nxt;
      p_ic_r <= p_ic_nxt;
      re2_r  <= re1_r;
      im2_r  <= im1_r;
      byp2_r <= byp1_r;
    end
  end

  // stage 3: combine, truncate toward zero, saturate
  function automatic quo_t trunc_q15(input sum_t s);
    sum_t bias;
    sum_t biased;
    bias            = '0;
    bias[FRAC_BITS-1:0] = {FRAC_BITS{s[PW]}};
    biased          = s + bias;
    return biased[PW:FRAC_BITS];
  endfunction

  function automatic logic [SAMPLE_BITS:0] saturate(input quo_t q);
    logic hit;
    smp_t val;
    hit = (q[QW-1:SAMPLE_BITS-1] != '0) && (q[QW-1:SAMPLE_BITS-1] != '1);
    if (hit) begin
      val = q[QW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      val = q[SAMPLE_BITS-1:0];
    end
    return {hit, val};
  endfunction

  sum_t sum_re, sum_im;
  logic [SAMPLE_BITS:0] sat_re, sat_im;
  smp_t out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  logic clipped_r, clipped_nxt;

  assign sum_re = sum_t'(p_rc_r) - sum_t'(p_is_r);
  assign sum_im = sum_t'(p_rs_r) + sum_t'(p_ic_r);
  assign sat_re = saturate(trunc_q15(sum_re));
  assign sat_im = saturate(trunc_q15(sum_im));

  always_comb begin
    if (byp2_r) begin
      out_re_nxt  = re2_r;
      out_im_nxt  = im2_r;
      clipped_nxt = 1'b0;
    end else begin
      out_re_nxt  = sat_re[SAMPLE_BITS-1:0];
      out_im_nxt  = sat_im[SAMPLE_BITS-1:0];
      clipped_nxt = sat_re[SAMPLE_BITS] || sat_im[SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      out_re_r  <= out_re_nxt;
      out_im_r  <= out_im_nxt;
      clipped_r <= clipped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_im_r, out_re_r});
  assign out_tuser  = clipped_r;

  // checks
  localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_burst_restarts_phase: assert property (@(posedge clk) disable iff (!rst_n)
    load1 && in_tuser |=> acc_r == $past(step_ext))
    else $error("burst start did not restart phase");

  a_phase_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !load1 |=> $stable(acc_r))
    else $error("phase moved without an accepted beat");

  a_bypass_never_clips: assert property (@(posedge clk) disable iff (!rst_n)
    load3 && byp2_r |=> out_tvalid && !clipped_r)
    else $error("bypassed beat flagged as clipped");

  a_clip_means_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clipped_r |->
      out_re_r == SMP_MAX || out_re_r == SMP_MIN ||
      out_im_r == SMP_MAX || out_im_r == SMP_MIN)
    else $error("clip flag without a saturated part");

endmodule
`default_nettype wire

/* dv/tb_nco_complex_frequency_shifter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nco_complex_frequency_shifter
// Streams I/Q samples through the frequency shifter under random idle cycles
// and backpressure. A local NCO and mixer model predicts each rotated sample,
// and every output beat is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_nco_complex_frequency_shifter;
  import ncfs_pkg::*;

  localparam int    HALF_PERIOD   = 6;
  localparam int    TABLE_SIZE    = 1024;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    STALL_LIMIT   = 3000;
  localparam int    MAX_REPORTS   = 10;
  localparam int    DRAIN_CYCLES  = 8;
  localparam int    IDLE_PERCENT  = 26;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               clip;
  } shifted_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [31:0] in_tdata  = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tready = 1'b0;
  logic       cfg_valid  = 1'b0;
  cfg_index_t cfg_index  = '0;
  cfg_data_t  cfg_data   = '0;
  wire        in_tready;
  wire        out_tvalid;
  wire [31:0] out_tdata;
  wire        out_tuser;
  wire        cfg_ready;

  // mixer model state
  logic [31:0] nco_phase    = '0;
  logic [31:0] phase_step_q = '0;
  logic        bypass_q     = 1'b1;
  int          sine_q15 [0:TABLE_SIZE];

  shifted_t    shift_pending [$];
  int          fail_count    = 0;
  int          idle_cycles   = 0;
  logic        gaps_on       = 1'b1;
  logic        receiver_hold = 1'b0;
  event        hold_kick;

  nco_complex_frequency_shifter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // sample_re, sample_im
    .in_tuser   (in_tuser),   // burst_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // rotated_re, rotated_im
    .out_tuser  (out_tuser),  // clipped
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // quarter-wave sine, q2.30 taylor series to x^13, rounded to q1.15
  function automatic void build_sine_table();
    longint unsigned kk;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    for (int k = 0; k <= TABLE_SIZE; k++) begin
      kk   = k;
      x    = (kk * HALF_PI_Q30) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (longint unsigned n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      sine_q15[k] = int'(r);
    end
  endfunction

  function automatic int wave_q15(input logic [1:0] quad, input int k);
    case (quad)
      2'd0: return sine_q15[k];
      2'd1: return sine_q15[TABLE_SIZE - k];
      2'd2: return -sine_q15[k];
      default: return -sine_q15[TABLE_SIZE - k];
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v, inout logic hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      hit = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // rotate one sample by the current phase, then advance the phase
  function automatic shifted_t mix_sample(input logic signed [15:0] re,
                                          input logic signed [15:0] im,
                                          input logic burst);
    shifted_t    r;
    logic [1:0]  quad;
    int          k;
    int          s;
    int          c;
    longint      a;
    longint      b;
    logic        hit;
    if (burst) begin
      nco_phase = '0;
    end
    r.re   = re;
    r.im   = im;
    r.clip = 1'b0;
    if (!bypass_q) begin
      hit  = 1'b0;
      quad = nco_phase[31:30];
      k    = int'(nco_phase[29:20]);
      s    = wave_q15(quad, k);
      c    = wave_q15(quad + 2'd1, k);
      a    = (longint'(re) * c - longint'(im) * s) / 32768;
      b    = (longint'(re) * s + longint'(im) * c) / 32768;
      r.re = clamp16(a, hit);
      r.im = clamp16(b, hit);
      r.clip = hit;
    end
    nco_phase = nco_phase + phase_step_q;
    return r;
  endfunction

  function automatic logic [15:0] random_part();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t random_step();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return cfg_data_t'($urandom_range(1, 1 << 22));
      3: return -cfg_data_t'($urandom_range(1, 1 << 22));
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (shift_pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                             input logic burst);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    in_tuser  <= burst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shift_pending.push_back(mix_sample(re, im, burst));
  endtask

  task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: phase_step_q = data;
      CFG_BYPASS:     bypass_q     = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(random_part(), random_part(), $urandom_range(31) == 0);
    end
  endtask

  // reset state is bypass; the phase still runs and must carry over
  task automatic test_bypass_passthrough();
    send_sample(16'h7fff, 16'h8000, 1'b1);
    write_register(CFG_PHASE_STEP, 32'h1000_0000);
    send_sample(16'h8000, 16'h7fff, 1'b0);
    send_sample(16'h0000, 16'hffff, 1'b0);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7fff, 16'h7fff, 1'b0);
    write_register(CFG_BYPASS, 32'hffff_fffe);
    send_sample(16'h7fff, 16'h1234, 1'b0);
  endtask

  task automatic test_rotation_corners();
    write_register(CFG_PHASE_STEP, 32'h0000_0000);
    send_sample(16'h7fff, 16'h0000, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h0000, 16'h7fff, 1'b0);
    // quarter turn per beat walks all four quadrants
    write_register(CFG_PHASE_STEP, 32'h4000_0000);
    send_sample(16'h8000, 16'h7fff, 1'b1);
    send_sample(16'h7fff, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7fff, 16'h7fff, 1'b0);
    // 45 degrees with full-scale parts saturates
    write_register(CFG_PHASE_STEP, 32'h2000_0000);
    send_sample(16'h8000, 16'h8000, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7fff, 16'h7fff, 1'b0);
    // negative step wraps below zero
    write_register(CFG_PHASE_STEP, 32'he000_0000);
    send_sample(16'h7fff, 16'h8000, 1'b1);
    send_sample(16'h8000, 16'h7fff, 1'b0);
    send_sample(16'h8000, 16'h8000, 1'b0);
    write_register(CFG_PHASE_STEP, 32'h7fff_ffff);
    send_sample(16'h7fff, 16'h7fff, 1'b1);
    send_sample(16'h7fff, 16'h7fff, 1'b0);
    write_register(CFG_PHASE_STEP, 32'h8000_0000);
    send_sample(16'h8000, 16'h7fff, 1'b1);
    send_sample(16'h8000, 16'h7fff, 1'b0);
  endtask

  // writes to unmapped indexes leave both registers alone
  task automatic test_unmapped_index();
    write_register(cfg_index_t'(2), 32'h0000_0001);
    write_register(cfg_index_t'(255), 32'hffff_ffff);
    send_sample(16'h4000, 16'hc000, 1'b0);
  endtask

  task automatic test_random_bursts();
    for (int phase = 0; phase < 6; phase++) begin
      write_register(CFG_PHASE_STEP, random_step());
      write_register(CFG_BYPASS, {31'($urandom), phase == 2});
      if ($urandom_range(1)) begin
        write_register(cfg_index_t'($urandom_range(2, 255)), $urandom);
      end
      send_random(200);
    end
  endtask

  // receiver stops long enough for the pipeline to fill and stall the input
  task automatic test_output_stall();
    write_register(CFG_PHASE_STEP, random_step());
    write_register(CFG_BYPASS, 32'h0000_0000);
    -> hold_kick;
    send_random(60);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_full_rate();
    gaps_on <= 1'b0;
    write_register(CFG_PHASE_STEP, random_step());
    send_random(150);
    gaps_on <= 1'b1;
  endtask

  initial begin
    forever begin
      @(hold_kick);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !receiver_hold && !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    shifted_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (shift_pending.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected beat: re %0d im %0d clip %0b",
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser);
        end
        fail_count++;
      end else begin
        want = shift_pending.pop_front();
        if (out_tdata[15:0] !== want.re || out_tdata[31:16] !== want.im ||
            out_tuser !== want.clip) begin
          if (fail_count < MAX_REPORTS) begin
            $display("mismatch: exp re %0d im %0d clip %0b, got re %0d im %0d clip %0b",
                     $signed(want.re), $signed(want.im), want.clip,
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    build_sine_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bypass_passthrough();
    test_rotation_corners();
    test_unmapped_index();
    test_random_bursts();
    test_output_stall();
    test_full_rate();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += shift_pending.size();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
